// File: rtl/kwm_pkg.sv
package kwm_pkg;

    localparam int MAX_WAYS   = 32;
    localparam int WAY_BITS   = $clog2(MAX_WAYS);
    localparam int VALUE_BITS = 31;
    localparam int CNT_BITS   = 6;

    localparam logic [CNT_BITS-1:0] NUM_WAYS_RESET = CNT_BITS'(20);
    localparam logic [CNT_BITS-1:0] CNT_MAX        = {CNT_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] WAYS_MAX       = CNT_BITS'(MAX_WAYS);

    localparam int S_TDATA_BITS = ((WAY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VALUE_BITS + WAY_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// File: rtl/k_way_merge_min_select.sv
// Channel  | Dir | Payload                                  | Handshake
// ---------+-----+------------------------------------------+----------------
// s_       | in  | tdata: way, head_value; tuser: exhausted | tvalid / tready
// m_       | out | tdata: low_head, refill_way; tuser: done | tvalid / tready
// cfg_     | in  | wdata: num_ways                          | we, no wait
//
// One item at a time. An item that yields a result is accepted, then the head
// memory is scanned (N = effective stream count: N reads, then the last compare,
// then closing the scan), and then the result is emitted. The single read port
// of the head memory and its registered read set the scan length.
// Reset (aresetn low, synchronous) clears control state and live flags; the
// head memory is not cleared. A stalled result sits in the output register
// while the next item is taken; a finished scan waits only for that register.
module k_way_merge_min_select
    import kwm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration: num_ways
    input  logic                    cfg_we,
    input  logic [CNT_BITS-1:0]     cfg_wdata,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // [4:0] way, [35:5] head_value, zero fill
    input  logic                    s_tuser,   // [0] exhausted
    // results
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // [30:0] low_head, [35:31] refill_way, zero fill
    output logic                    m_tuser    // [0] done_res
);

    // input fields
    logic [WAY_BITS-1:0]   in_way;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_gone;

    assign in_way   = s_tdata[WAY_BITS-1:0];
    assign in_value = s_tdata[WAY_BITS+VALUE_BITS-1:WAY_BITS];
    assign in_gone  = s_tuser;

    // control state
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   num_ways_reg;
    logic [MAX_WAYS-1:0]   live_reg, live_next;
    logic [CNT_BITS-1:0]   loaded_reg, loaded_next;
    logic                  merging_reg, merging_next;

    // scan pipeline
    logic [CNT_BITS-1:0]   scan_addr_reg, scan_addr_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [WAY_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [WAY_BITS-1:0]   best_idx_reg, best_idx_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [WAY_BITS-1:0]   out_way_reg, out_way_next;
    logic                  out_done_reg, out_done_next;

    // memory port
    logic                  ram_we;
    logic                  ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    // effective stream count: saturate to 1..MAX_WAYS
    logic [CNT_BITS-1:0]   eff_n;
    logic [CNT_BITS-1:0]   loaded_inc;
    logic                  accept;
    logic                  in_range;
    logic                  issue;
    logic                  take;

    always_comb begin
        if (num_ways_reg == '0) begin
            eff_n = CNT_BITS'(1);
        end else if (num_ways_reg > WAYS_MAX) begin
            eff_n = WAYS_MAX;
        end else begin
            eff_n = num_ways_reg;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_range   = CNT_BITS'(in_way) < eff_n;
    assign loaded_inc = (loaded_reg == CNT_MAX) ? loaded_reg : loaded_reg + 1'b1;
    assign issue      = (state_reg == ST_SCAN) && (scan_addr_reg < eff_n);
    assign take       = cmp_valid_reg && live_reg[cmp_idx_reg]
                        && (!found_reg || ram_rdata <= best_reg);

    assign ram_we = accept && in_range && !in_gone;
    assign ram_re = issue;

    kwm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WAYS)
    ) u_heads (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_way),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (scan_addr_reg[WAY_BITS-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        live_next      = live_reg;
        loaded_next    = loaded_reg;
        merging_next   = merging_reg;
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = issue;
        cmp_idx_next   = scan_addr_reg[WAY_BITS-1:0];
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_way_next   = out_way_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // store the item; drop it if the way is beyond the stream count
                if (accept && in_range) begin
                    live_next[in_way] = !in_gone;
                    scan_addr_next    = '0;
                    found_next        = 1'b0;
                    if (merging_reg) begin
                        state_next = ST_SCAN;
                    end else begin
                        loaded_next = loaded_inc;
                        if (loaded_inc >= eff_n) begin
                            merging_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                // ties go to the later way, hence <=
                if (take) begin
                    found_next    = 1'b1;
                    best_next     = ram_rdata;
                    best_idx_next = cmp_idx_reg;
                end
                if (!issue && !cmp_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_value_next = found_reg ? best_reg : '0;
                    out_way_next   = found_reg ? best_idx_reg : '0;
                    out_done_next  = !found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            num_ways_reg  <= NUM_WAYS_RESET;
            live_reg      <= '0;
            loaded_reg    <= '0;
            merging_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            loaded_reg    <= loaded_next;
            merging_reg   <= merging_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                num_ways_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        out_value_reg <= out_value_next;
        out_way_reg   <= out_way_next;
        out_done_reg  <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_way_reg, out_value_reg});
    assign m_tuser  = out_done_reg;

endmodule

// File: rtl/kwm_ram.sv
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kwm_checker.sv
module kwm_checker
    import kwm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tready,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,
    input  logic                    m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // done result carries zero value and way
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("done result with non-zero payload");

    // a result appears only after the input side has been closed for the scan
    a_emit_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input was open");

    // after reset: idle, no pending result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind k_way_merge_min_select kwm_checker u_kwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/tb_k_way_merge_min_select.sv
module tb_k_way_merge_min_select;
    import kwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Slowest item: accept, scan of up to MAX_WAYS heads, emit. Leave some slack on top.
    localparam int SETTLE_CYCLES = MAX_WAYS + 8;
    // Input items are counted per phase; the phases together give roughly 1800.
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASES = 8;
    localparam logic [VALUE_BITS-1:0] HEAD_MAX = '1;

    typedef enum {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idling_t;

    // One emitted result: the smallest live head and its stream, or the done flag.
    typedef struct packed {
        logic [VALUE_BITS-1:0] low_head;
        logic [WAY_BITS-1:0]   refill_way;
        logic                  done;
    } min_pick_t;

    // Directed script: either a write of the stream count or one head item.
    // Pinned rows carry a result typed in by hand instead of the predicted one.
    typedef struct {
        bit                    is_cfg;
        logic [CNT_BITS-1:0]   ways;
        logic [WAY_BITS-1:0]   way;
        logic [VALUE_BITS-1:0] value;
        logic                  gone;
        bit                    pinned;
        min_pick_t             want;
    } script_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CNT_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;

    k_way_merge_min_select dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the stream count and the head store
    // ------------------------------------------------------------------
    logic [CNT_BITS-1:0]   ways_setting = NUM_WAYS_RESET;
    logic [VALUE_BITS-1:0] stored_head [MAX_WAYS];
    logic [MAX_WAYS-1:0]   head_held = '0;
    int unsigned           load_tally = 0;
    int unsigned           drained_tally = 0;
    bit                    merge_on = 1'b0;

    min_pick_t   pending_picks [$];
    min_pick_t   last_pick = '0;
    int unsigned items_sent = 0;
    int unsigned item_goal = 0;
    int unsigned mismatches = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    script_row_t script [$];

    int      phase_ways [PHASES] = '{32, 1, 7, 63, 20, 0, 13, 32};
    idling_t phase_idling [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_SEND, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

    // Saturate the programmed count to 1..MAX_WAYS; zero behaves as one stream.
    function automatic int unsigned active_ways();
        if (ways_setting == '0)
            return 1;
        if (ways_setting > WAYS_MAX)
            return MAX_WAYS;
        return 32'(ways_setting);
    endfunction

    // Apply one accepted item to the predictor; return 1 when it yields a result.
    function automatic bit take_head(input logic [WAY_BITS-1:0] way,
                                     input logic [VALUE_BITS-1:0] value,
                                     input logic gone,
                                     output min_pick_t pick);
        int unsigned n;
        int unsigned i;
        bit found;
        pick = '0;
        found = 1'b0;
        n = active_ways();
        // drop items for streams beyond the active count
        if (way >= n)
            return 1'b0;
        if (gone) begin
            // a stream counts as finished when it held a value, or is empty from the start
            if ((head_held[way] || !merge_on) && drained_tally < CNT_MAX)
                drained_tally++;
            head_held[way] = 1'b0;
        end else begin
            stored_head[way] = value;
            head_held[way] = 1'b1;
        end
        if (!merge_on) begin
            if (load_tally < CNT_MAX)
                load_tally++;
            if (load_tally < n)
                return 1'b0;
            merge_on = 1'b1;
        end
        // lowest head wins; on a tie the later (higher) stream takes over
        for (i = 0; i < n; i++) begin
            if (head_held[i] && (!found || stored_head[i] <= pick.low_head)) begin
                found = 1'b1;
                pick.low_head = stored_head[i];
                pick.refill_way = WAY_BITS'(i);
            end
        end
        pick.done = !found;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed script builders
    // ------------------------------------------------------------------
    function automatic void script_ways(input logic [CNT_BITS-1:0] ways);
        script_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.ways = ways;
        script.push_back(row);
    endfunction

    function automatic void script_head(input logic [WAY_BITS-1:0] way,
                                        input logic [VALUE_BITS-1:0] value,
                                        input logic gone);
        script_row_t row;
        row = '{default: '0};
        row.way = way;
        row.value = value;
        row.gone = gone;
        script.push_back(row);
    endfunction

    function automatic void script_pinned(input logic [WAY_BITS-1:0] way,
                                          input logic [VALUE_BITS-1:0] value,
                                          input logic gone,
                                          input logic [VALUE_BITS-1:0] low_head,
                                          input logic [WAY_BITS-1:0] refill_way,
                                          input logic done);
        script_row_t row;
        row = '{default: '0};
        row.way = way;
        row.value = value;
        row.gone = gone;
        row.pinned = 1'b1;
        row.want.low_head = low_head;
        row.want.refill_way = refill_way;
        row.want.done = done;
        script.push_back(row);
    endfunction

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct = 0;
                stall_pct = 0;
            end
            IDLE_SEND: begin
                gap_pct = 78;
                stall_pct = 0;
            end
            IDLE_RECV: begin
                gap_pct = 0;
                stall_pct = 78;
            end
            default: begin
                gap_pct = 20;
                stall_pct = 20;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: called at a rising edge; returns at the edge where the item is taken.
    // The predictor runs at that edge, so the next item can follow its refill_way.
    // ------------------------------------------------------------------
    task automatic offer_head(input logic [WAY_BITS-1:0] way,
                              input logic [VALUE_BITS-1:0] value,
                              input logic gone,
                              input bit pinned,
                              input min_pick_t pinned_pick);
        min_pick_t pick;
        bit emits;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS - WAY_BITS - VALUE_BITS){1'b0}}, value, way};
        s_tuser  <= gone;
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
        emits = take_head(way, value, gone, pick);
        if (emits)
            last_pick = pick;
        if (pinned)
            pending_picks.push_back(pinned_pick);
        else if (emits)
            pending_picks.push_back(pick);
    endtask

    // Hold the input idle until every result is back and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ways(input logic [CNT_BITS-1:0] ways);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= ways;
        @(posedge aclk);
        ways_setting = ways;
        cfg_we <= 1'b0;
    endtask

    // A well-formed merge: load every active stream once, then keep refilling the
    // stream named by the last result with a value no lower than its old head,
    // until every stream has run dry, 400 refills are done or the phase has sent enough items.
    // A little noise is mixed in.
    task automatic merge_round();
        int unsigned n;
        int unsigned first;
        int unsigned i;
        int unsigned refills;
        bit narrow;
        logic [WAY_BITS-1:0] way;
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] step;
        logic gone;
        n = active_ways();
        // narrow rounds keep values tiny so that ties between streams are common
        narrow = $urandom_range(1);
        first = $urandom_range(n - 1);
        for (i = 0; i < n; i++) begin
            way = WAY_BITS'((first + i) % n);
            value = narrow ? VALUE_BITS'($urandom_range(15)) : VALUE_BITS'($urandom);
            gone = ($urandom_range(7) == 0);
            offer_head(way, value, gone, 1'b0, '0);
            if (n < MAX_WAYS && $urandom_range(19) == 0)
                offer_head(WAY_BITS'($urandom_range(MAX_WAYS - 1, n)), VALUE_BITS'($urandom),
                           1'($urandom_range(1)), 1'b0, '0);
        end
        refills = 0;
        while (!last_pick.done && refills < 400 && items_sent < item_goal) begin
            refills++;
            if ($urandom_range(24) == 0) begin
                // refill some other stream out of turn
                offer_head(WAY_BITS'($urandom_range(n - 1)), VALUE_BITS'($urandom),
                           ($urandom_range(3) == 0), 1'b0, '0);
            end else begin
                step = narrow ? VALUE_BITS'($urandom_range(3))
                              : VALUE_BITS'($urandom_range(32'h0400_0000));
                gone = ($urandom_range(5) == 0) || (last_pick.low_head > HEAD_MAX - step);
                offer_head(last_pick.refill_way, last_pick.low_head + step, gone, 1'b0, '0);
            end
        end
    endtask

    // Unstructured items: any way, any value, exhausted now and then.
    task automatic noise_burst();
        int unsigned i;
        for (i = 0; i < 12; i++)
            offer_head(WAY_BITS'($urandom), VALUE_BITS'($urandom),
                       ($urandom_range(3) == 0), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver and result check: stall at random, compare each taken result
    // field by field against the oldest pending pick.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        min_pick_t wanted;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_picks.size() == 0) begin
                $error("result with no pick pending: low_head %0h refill_way %0d done_res %0b",
                       m_tdata[VALUE_BITS-1:0], m_tdata[VALUE_BITS +: WAY_BITS], m_tuser);
                mismatches++;
            end else begin
                wanted = pending_picks.pop_front();
                if (m_tdata[VALUE_BITS-1:0] !== wanted.low_head) begin
                    $error("low_head: expected %0h, got %0h",
                           wanted.low_head, m_tdata[VALUE_BITS-1:0]);
                    mismatches++;
                end
                if (m_tdata[VALUE_BITS +: WAY_BITS] !== wanted.refill_way) begin
                    $error("refill_way: expected %0d, got %0d",
                           wanted.refill_way, m_tdata[VALUE_BITS +: WAY_BITS]);
                    mismatches++;
                end
                if (m_tuser !== wanted.done) begin
                    $error("done_res: expected %0b, got %0b", wanted.done, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned p;

        // Loading phase with three streams: drop an out-of-range item, load stream 0
        // as empty, then load stream 1 twice so the later exhausted mark wins.
        // Nothing is live when the third load lands, so the first result is done.
        script_ways(6'd3);
        script_head(5'd5, 31'd77, 1'b0);
        script_head(5'd0, HEAD_MAX, 1'b1);
        script_head(5'd1, 31'd7, 1'b0);
        script_pinned(5'd1, 31'd7, 1'b1, 31'd0, 5'd0, 1'b1);
        // merging from here on: single head, then a tie that the higher stream takes
        script_pinned(5'd2, 31'd5, 1'b0, 31'd5, 5'd2, 1'b0);
        script_pinned(5'd1, 31'd5, 1'b0, 31'd5, 5'd2, 1'b0);
        script_head(5'd2, HEAD_MAX, 1'b0);
        script_pinned(5'd1, 31'd0, 1'b1, HEAD_MAX, 5'd2, 1'b0);
        script_pinned(5'd0, 31'd0, 1'b0, 31'd0, 5'd0, 1'b0);
        script_head(5'd0, 31'd0, 1'b1);
        // run every stream dry, then keep feeding after done
        script_pinned(5'd2, HEAD_MAX, 1'b1, 31'd0, 5'd0, 1'b1);
        script_pinned(5'd1, 31'd0, 1'b1, 31'd0, 5'd0, 1'b1);
        script_head(5'd31, HEAD_MAX, 1'b0);
        script_head(5'd1, 31'd0, 1'b0);
        // count above the maximum saturates to all streams; stream 31 becomes reachable
        script_ways(6'd63);
        script_head(5'd31, HEAD_MAX, 1'b0);
        script_pinned(5'd1, 31'd0, 1'b1, HEAD_MAX, 5'd31, 1'b0);
        script_head(5'd30, HEAD_MAX, 1'b0);
        // count of zero acts as one stream
        script_ways(6'd0);
        script_head(5'd31, 31'd0, 1'b0);
        script_pinned(5'd0, 31'd9, 1'b0, 31'd9, 5'd0, 1'b0);
        script_pinned(5'd0, 31'd0, 1'b1, 31'd0, 5'd0, 1'b1);
        script_ways(6'd32);
        script_head(5'd16, 31'h2AAA_AAAA, 1'b0);
        script_head(5'd8, 31'h5555_5555, 1'b0);

        set_idling(IDLE_NONE);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[r]) begin
            if (script[r].is_cfg)
                write_ways(script[r].ways);
            else
                offer_head(script[r].way, script[r].value, script[r].gone,
                           script[r].pinned, script[r].want);
        end

        // Random part: each phase sets a stream count and an idling pattern,
        // then runs merges until enough items have been sent.
        for (p = 0; p < PHASES; p++) begin
            write_ways(CNT_BITS'(phase_ways[p]));
            set_idling(phase_idling[p]);
            item_goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < item_goal) begin
                if ($urandom_range(99) < 85)
                    merge_round();
                else
                    noise_burst();
            end
        end

        // wait for the last results, and a little longer for anything stray
        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/k_way_merge_min_select.sv
rtl/kwm_checker.sv
test/tb_k_way_merge_min_select.sv
